@@ hw/rtl/lrupr_pkg.sv @@
// Shared types and constants of the LRU page replacement list.
package lrupr_pkg;

    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 2;
    localparam int VICTIM_W   = 20;
    localparam int COUNT_W    = 5;
    localparam int M_TDATA_W  = 32;
    localparam int M_TDATA_PAD = M_TDATA_W - VICTIM_W - COUNT_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_TOUCH  = 2'd1,
        ACT_EVICT  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE    = 2'd0,
        S_COMPARE = 2'd1,
        S_UPDATE  = 2'd2
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic compare;
        logic update;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

@@ hw/rtl/lrupr_ctrl.sv @@
// Controller state machine that sequences compare and update of each transaction.
module lrupr_ctrl
    import lrupr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        s_tready    = 1'b0;
        cmd         = '0;
        state_next  = state_reg;
        accept      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                accept   = s_tvalid;
                if (accept)
                begin
                    state_next = S_COMPARE;
                end
            end
            S_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next  = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (status.out_free)
                begin
                    cmd.update = 1'b1;
                    s_tready   = 1'b1;
                    accept     = s_tvalid;
                    state_next = accept ? S_COMPARE : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        cmd.load = accept;
    end

endmodule

@@ hw/rtl/lrupr_datapath.sv @@
// Datapath: recency register row, parallel compare, shift update and result register.
module lrupr_datapath
    import lrupr_pkg::*;
#(
    parameter int ENTRIES   = 16,
    parameter int PAGE_BITS = 20
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           status,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic [ACTION_W-1:0]  action_in,
    input  logic [PAGE_BITS-1:0] page_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATUS_W-1:0]  out_status,
    output logic [VICTIM_W-1:0]  out_victim,
    output logic [COUNT_W-1:0]   out_count
);

    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [PAGE_BITS-1:0] entry_reg  [ENTRIES];
    logic [PAGE_BITS-1:0] entry_next [ENTRIES];
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    action_t              action_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic [ENTRIES-1:0]   match_reg;
    logic [ENTRIES-1:0]   match_next;
    logic [ENTRIES-1:0]   prefix;
    logic [ENTRIES-1:0]   shift_mask;
    logic                 track_reg;
    logic                 hit;
    logic                 do_promote;
    logic                 do_append;
    logic                 do_evict;
    status_t              status_d;
    logic [VICTIM_W-1:0]  victim_d;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    status_t              out_status_reg;
    logic [VICTIM_W-1:0]  out_victim_reg;
    logic [COUNT_W-1:0]   out_count_reg;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_next[i] = (entry_reg[i] == page_reg) && (CNT_W'(i) < count_reg);
        end
    end

    always_comb
    begin
        prefix[0] = match_reg[0];
        for (int i = 1; i < ENTRIES; i++)
        begin
            prefix[i] = prefix[i-1] | match_reg[i];
        end
    end

    assign hit = |match_reg;

    always_comb
    begin
        do_promote = 1'b0;
        do_append  = 1'b0;
        do_evict   = 1'b0;
        status_d   = ST_OK;
        victim_d   = '0;
        count_next = count_reg;
        unique case (action_reg)
            ACT_INSERT:
            begin
                if (hit)
                begin
                    do_promote = 1'b1;
                end
                else if (count_reg == CNT_W'(ENTRIES))
                begin
                    status_d = ST_FULL;
                end
                else
                begin
                    do_append  = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            ACT_TOUCH:
            begin
                if (track_reg)
                begin
                    if (hit)
                    begin
                        do_promote = 1'b1;
                    end
                    else
                    begin
                        status_d = ST_NOT_FOUND;
                    end
                end
            end
            ACT_EVICT:
            begin
                if (count_reg == '0)
                begin
                    status_d = ST_EMPTY;
                end
                else
                begin
                    do_evict   = 1'b1;
                    victim_d   = VICTIM_W'(entry_reg[0]);
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_d = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        shift_mask = '0;
        if (do_promote)
        begin
            shift_mask = prefix;
        end
        else if (do_evict)
        begin
            shift_mask = '1;
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            entry_next[i] = entry_reg[i];
        end
        for (int i = 0; i < ENTRIES - 1; i++)
        begin
            if (shift_mask[i])
            begin
                entry_next[i] = entry_reg[i+1];
            end
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (do_promote && (CNT_W'(i + 1) == count_reg))
            begin
                entry_next[i] = page_reg;
            end
            if (do_append && (CNT_W'(i) == count_reg))
            begin
                entry_next[i] = page_reg;
            end
        end
    end

    assign out_valid_next = cmd.update | (out_valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            track_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.update)
            begin
                count_reg <= count_next;
            end
            if (cfg_we)
            begin
                track_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action_t'(action_in);
            page_reg   <= page_in;
        end
        if (cmd.compare)
        begin
            match_reg <= match_next;
        end
        if (cmd.update)
        begin
            entry_reg      <= entry_next;
            out_status_reg <= status_d;
            out_victim_reg <= victim_d;
            out_count_reg  <= COUNT_W'(count_next);
        end
    end

    assign status.out_free = ~out_valid_reg | out_ready;
    assign out_valid       = out_valid_reg;
    assign out_status      = out_status_reg;
    assign out_victim      = out_victim_reg;
    assign out_count       = out_count_reg;

endmodule

@@ hw/rtl/lru_page_replacement.sv @@
// Top level of the LRU page replacement list with its stream ports.
// The block holds up to ENTRIES page numbers in recency order and answers every
// transaction with exactly one result. The compare state compares the page against all
// held entries in parallel, then the update state shifts the register row and loads
// the result register, waiting while a result is still pending. New transactions are
// taken in idle or along with an update; a result waits in its register while the next
// transaction is compared. The user writes tracking_enable through cfg_we and cfg_wdata
// only while no transaction is in flight; the block itself does not enforce this.
module lru_page_replacement
    import lrupr_pkg::*;
#(
    parameter int ENTRIES   = 16,
    parameter int PAGE_BITS = 20
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic                                 cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // Fields from bit 0: page_number.
    input  logic [((PAGE_BITS + 7) / 8) * 8-1:0] s_tdata,
    // Fields from bit 0: action.
    input  logic [ACTION_W-1:0]                  s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // Fields from bit 0: victim_page, entry_count.
    output logic [M_TDATA_W-1:0]                 m_tdata,
    // Fields from bit 0: status.
    output logic [STATUS_W-1:0]                  m_tuser
);

    ctrl_cmd_t           cmd;
    dp_status_t          dp_status;
    logic [VICTIM_W-1:0] victim;
    logic [COUNT_W-1:0]  count;

    lrupr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (dp_status),
        .cmd      (cmd)
    );

    lrupr_datapath #(
        .ENTRIES   (ENTRIES),
        .PAGE_BITS (PAGE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (dp_status),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .action_in  (s_tuser),
        .page_in    (s_tdata[PAGE_BITS-1:0]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_victim (victim),
        .out_count  (count)
    );

    assign m_tdata = {{M_TDATA_PAD{1'b0}}, count, victim};

`ifndef NO_ASSERTIONS
    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> !(m_tvalid && !m_tready))
        else $error("Result register loaded while a result was still pending.");

    a_two_cycle_transaction: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("Transaction accepted in back-to-back cycles.");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_EMPTY)) |-> (victim == '0 && count == '0))
        else $error("Evict on empty reported a page or a nonzero count.");

    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_FULL)) |-> (count == COUNT_W'(ENTRIES)))
        else $error("Insert reported full while the table was not full.");
`endif

endmodule

@@ verif/tb_lru_page_replacement.sv @@
// Testbench for the LRU page replacement list: stream stimulus, recency predictor, scoreboard.
`timescale 1ns / 100ps

module tb_lru_page_replacement;
    import lrupr_pkg::*;

    localparam int ENTRIES   = 16;
    localparam int PAGE_W    = 20;
    localparam int S_TDATA_W = ((PAGE_W + 7) / 8) * 8;
    localparam int POOL_SIZE = 24;
    localparam int HOLD_LEN  = 80;

    typedef struct {
        status_t              status;
        logic [VICTIM_W-1:0]  victim;
        logic [COUNT_W-1:0]   count;
    } lru_result_t;

    class lru_scoreboard;
        logic [PAGE_W-1:0] order[ENTRIES];
        int                held;
        logic              tracking;
        lru_result_t       expected_q[$];
        int                errors;

        function new();
            held = 0;
            tracking = 1'b0;
            errors = 0;
        endfunction

        function int find_page(logic [PAGE_W-1:0] page);
            for (int i = 0; i < held; i++)
            begin
                if (order[i] == page)
                    return i;
            end
            return -1;
        endfunction

        function void promote(int pos);
            logic [PAGE_W-1:0] page;
            page = order[pos];
            for (int i = pos; i + 1 < held; i++)
                order[i] = order[i + 1];
            order[held - 1] = page;
        endfunction

        function void note_input(action_t act, logic [PAGE_W-1:0] page);
            lru_result_t exp;
            int          pos;
            exp.status = ST_OK;
            exp.victim = '0;
            unique case (act)
                ACT_INSERT:
                begin
                    pos = find_page(page);
                    if (pos >= 0)
                        promote(pos);
                    else if (held >= ENTRIES)
                        exp.status = ST_FULL;
                    else
                    begin
                        order[held] = page;
                        held++;
                    end
                end
                ACT_TOUCH:
                begin
                    if (tracking)
                    begin
                        pos = find_page(page);
                        if (pos >= 0)
                            promote(pos);
                        else
                            exp.status = ST_NOT_FOUND;
                    end
                end
                ACT_EVICT:
                begin
                    if (held == 0)
                        exp.status = ST_EMPTY;
                    else
                    begin
                        exp.victim = order[0];
                        for (int i = 0; i + 1 < held; i++)
                            order[i] = order[i + 1];
                        held--;
                    end
                end
                default:
                begin
                end
            endcase
            exp.count = held[COUNT_W-1:0];
            expected_q.push_back(exp);
        endfunction

        function void check_result(status_t status, logic [VICTIM_W-1:0] victim,
                                   logic [COUNT_W-1:0] count);
            lru_result_t exp;
            if (expected_q.size() == 0)
            begin
                $error("Result transaction arrived with no expected result pending.");
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            if (status !== exp.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", exp.status, status);
                errors++;
            end
            if (victim !== exp.victim)
            begin
                $error("victim_page mismatch: expected 0x%05h, actual 0x%05h", exp.victim, victim);
                errors++;
            end
            if (count !== exp.count)
            begin
                $error("entry_count mismatch: expected %0d, actual %0d", exp.count, count);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic                 cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [ACTION_W-1:0]  s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    lru_scoreboard     book = new();
    int                n_inputs;
    int                n_results;
    int                status_seen[4];
    int                cfg_writes;
    bit                burst_mode;
    bit                stall_request;
    logic [PAGE_W-1:0] page_pool[POOL_SIZE];

    lru_page_replacement #(
        .ENTRIES   (ENTRIES),
        .PAGE_BITS (PAGE_W)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            book.check_result(status_t'(m_tuser), m_tdata[VICTIM_W-1:0],
                              m_tdata[VICTIM_W +: COUNT_W]);
            status_seen[m_tuser]++;
            n_results++;
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            book.note_input(action_t'(s_tuser), s_tdata[PAGE_W-1:0]);
            n_inputs++;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    initial
    begin
        int r;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            r = $urandom_range(0, 99);
            if (stall_request)
            begin
                stall_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
            end
            else if (burst_mode || r < 65)
                m_tready <= 1'b1;
            else if (r < 95)
                m_tready <= 1'b0;
            else
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(8, 40)) @(posedge clk);
            end
        end
    end

    task automatic offer_request(action_t act, logic [PAGE_W-1:0] page);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(S_TDATA_W - PAGE_W){1'b0}}, page};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic write_tracking(logic value);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        book.tracking = value;
        cfg_writes++;
    endtask

    task automatic run_random_phase(int items, int insert_weight);
        int      r;
        action_t act;
        logic [PAGE_W-1:0] page;
        for (int i = 0; i < POOL_SIZE; i++)
            page_pool[i] = PAGE_W'($urandom_range(0, (1 << PAGE_W) - 1));
        page_pool[0] = '0;
        page_pool[1] = '1;
        for (int n = 0; n < items; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < insert_weight)
                act = ACT_INSERT;
            else if (r < insert_weight + 35)
                act = ACT_TOUCH;
            else if (r < 97)
                act = ACT_EVICT;
            else
                act = ACT_NONE;
            if ($urandom_range(0, 99) < 80)
                page = page_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                page = PAGE_W'($urandom_range(0, (1 << PAGE_W) - 1));
            offer_request(act, page);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = ACT_NONE;
        burst_mode    = 1'b0;
        stall_request = 1'b0;
        n_inputs      = 0;
        n_results     = 0;
        cfg_writes    = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Tracking is off after reset: touches must be ignored, inserts still reorder.
        offer_request(ACT_EVICT, 20'h00000);
        offer_request(ACT_NONE, 20'hFFFFF);
        offer_request(ACT_TOUCH, 20'h00005);
        offer_request(ACT_INSERT, 20'h00000);
        offer_request(ACT_INSERT, 20'hFFFFF);
        offer_request(ACT_INSERT, 20'h00000);
        offer_request(ACT_TOUCH, 20'hFFFFF);
        offer_request(ACT_EVICT, 20'h12345);

        write_tracking(1'b1);
        offer_request(ACT_TOUCH, 20'h12345);
        for (int i = 0; i < ENTRIES - 1; i++)
            offer_request(ACT_INSERT, 20'h00001 << i);
        offer_request(ACT_INSERT, 20'hABCDE);
        offer_request(ACT_TOUCH, 20'h00004);
        offer_request(ACT_EVICT, 20'h00000);

        write_tracking(1'b0);
        run_random_phase(100, 55);

        write_tracking(1'b1);
        run_random_phase(100, 50);

        // The receiver holds off while the sender keeps offering back to back.
        write_tracking(1'b1);
        stall_request = 1'b1;
        burst_mode    = 1'b1;
        run_random_phase(20, 50);
        burst_mode    = 1'b0;
        run_random_phase(80, 30);

        write_tracking(1'b0);
        burst_mode = 1'b1;
        run_random_phase(100, 45);
        burst_mode = 1'b0;

        write_tracking(1'b1);
        run_random_phase(100, 60);

        write_tracking(1'b1);
        run_random_phase(100, 25);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d request transactions and %0d results over %0d tracking writes.",
                 n_inputs, n_results, cfg_writes);
        $display("Statuses seen: ok %0d, not found %0d, empty %0d, full %0d.",
                 status_seen[ST_OK], status_seen[ST_NOT_FOUND],
                 status_seen[ST_EMPTY], status_seen[ST_FULL]);
        if (book.errors == 0 && book.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
